// ===== rtl/v3mu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3mu_pkg: shared types and constants for the vector math unit
// Opcodes, field widths and the payload that moves along the root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package v3mu_pkg;

   localparam int COMP_W  = 16;   // Q4.12 input component
   localparam int RES_W   = 33;   // result component
   localparam int LSQ_W   = 32;   // squared length
   localparam int ROOT_W  = 17;   // root / quotient bits, one per cell
   localparam int ACC_W   = 66;   // running square and compare width
   localparam int LANES   = 4;    // lane 0 length, lanes 1..3 normalize

   typedef enum logic [2:0] {
      OP_DOT   = 3'd0,
      OP_CROSS = 3'd1,
      OP_LSQ   = 3'd2,
      OP_LEN   = 3'd3,
      OP_NORM  = 3'd4
   } op_type;

   // one request in flight through the cell chain
   typedef struct packed {
      logic                                  valid;
      logic [2:0]                            op;
      logic signed [RES_W-1:0]               sc_x;
      logic signed [RES_W-1:0]               sc_y;
      logic signed [RES_W-1:0]               sc_z;
      logic [LSQ_W-1:0]                      lsq;
      logic [2:0]                            neg;
      logic [2:0][ACC_W-1:0]                 num;
      logic [LANES-1:0][ACC_W-1:0]           sq;
      logic [LANES-1:0][ACC_W-1:0]           lin;
      logic [LANES-1:0][ROOT_W-1:0]          q;
   } cell_type;

endpackage

`default_nettype wire

// ===== rtl/v3mu_front.sv =====
// ----------------------------------------------------------------------------
// v3mu_front: input register, products and sums
// Registers the request, forms all twelve products, then dot, cross, squared
// length and the normalize targets, and loads the first cell.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_front import v3mu_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     req_valid,
   input  wire logic [2:0]               req_opcode,
   input  wire logic signed [COMP_W-1:0] req_a_x,
   input  wire logic signed [COMP_W-1:0] req_a_y,
   input  wire logic signed [COMP_W-1:0] req_a_z,
   input  wire logic signed [COMP_W-1:0] req_b_x,
   input  wire logic signed [COMP_W-1:0] req_b_y,
   input  wire logic signed [COMP_W-1:0] req_b_z,
   output cell_type                      cell_out
);

   localparam int PW = 2 * COMP_W;

   logic                     v0_ff;
   logic [2:0]               op0_ff;
   logic signed [COMP_W-1:0] a_ff [3];
   logic signed [COMP_W-1:0] b_ff [3];

   logic                     v1_ff;
   logic [2:0]               op1_ff;
   logic [2:0]               neg1_ff;
   // dot terms, cross terms, squares
   logic signed [PW-1:0]     pd_ff [3];
   logic signed [PW-1:0]     pc_ff [6];
   logic signed [PW-1:0]     ps_ff [3];

   cell_type                 cell_ff;
   cell_type                 cell_in;

   logic signed [PW+1:0]     dot;
   logic [LSQ_W-1:0]         lsq;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
      if (en) begin
         op0_ff  <= req_opcode;
         a_ff[0] <= req_a_x;
         a_ff[1] <= req_a_y;
         a_ff[2] <= req_a_z;
         b_ff[0] <= req_b_x;
         b_ff[1] <= req_b_y;
         b_ff[2] <= req_b_z;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
      if (en) begin
         op1_ff   <= op0_ff;
         neg1_ff  <= {a_ff[2][COMP_W-1], a_ff[1][COMP_W-1], a_ff[0][COMP_W-1]};
         pd_ff[0] <= a_ff[0] * b_ff[0];
         pd_ff[1] <= a_ff[1] * b_ff[1];
         pd_ff[2] <= a_ff[2] * b_ff[2];
         pc_ff[0] <= a_ff[1] * b_ff[2];
         pc_ff[1] <= a_ff[2] * b_ff[1];
         pc_ff[2] <= a_ff[2] * b_ff[0];
         pc_ff[3] <= a_ff[0] * b_ff[2];
         pc_ff[4] <= a_ff[0] * b_ff[1];
         pc_ff[5] <= a_ff[1] * b_ff[0];
         ps_ff[0] <= a_ff[0] * a_ff[0];
         ps_ff[1] <= a_ff[1] * a_ff[1];
         ps_ff[2] <= a_ff[2] * a_ff[2];
      end
   end

   // sums and chain load
   always_comb begin
      dot = (PW+2)'(pd_ff[0]) + (PW+2)'(pd_ff[1]) + (PW+2)'(pd_ff[2]);
      lsq = ps_ff[0][LSQ_W-1:0] + ps_ff[1][LSQ_W-1:0] + ps_ff[2][LSQ_W-1:0];

      cell_in       = '0;
      cell_in.valid = v1_ff;
      cell_in.op    = op1_ff;
      cell_in.neg   = neg1_ff;
      cell_in.lsq   = lsq;
      for (int i = 0; i < 3; i++) begin
         // a squared fits in 31 bits; target is a^2 * 2^24
         cell_in.num[i] = {11'b0, ps_ff[i][30:0], 24'b0};
      end
      case (op1_ff)
         OP_DOT: begin
            cell_in.sc_x = dot[RES_W-1:0];
         end
         OP_CROSS: begin
            cell_in.sc_x = RES_W'(pc_ff[0]) - RES_W'(pc_ff[1]);
            cell_in.sc_y = RES_W'(pc_ff[2]) - RES_W'(pc_ff[3]);
            cell_in.sc_z = RES_W'(pc_ff[4]) - RES_W'(pc_ff[5]);
         end
         OP_LSQ: begin
            cell_in.sc_x = RES_W'(lsq);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (en) begin
         cell_ff[$bits(cell_type)-2:0] <= cell_in[$bits(cell_type)-2:0];
      end
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/v3mu_cell.sv =====
// ----------------------------------------------------------------------------
// v3mu_cell: one bit of the root / quotient search
// Each lane tries to set bit BIT of q under the test q^2 * m <= target, with
// q^2*m and q*m kept as running sums so the trial is two shifts and adds.
// Lane 0: m = 1, target = |A|^2 (floor root). Lanes 1..3: m = |A|^2,
// target = a_i^2 * 2^24 (normalized magnitude).
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_cell import v3mu_pkg::*; #(
   parameter int BIT = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  cell_type  cell_in,
   output cell_type  cell_out
);

   cell_type         cell_ff;
   cell_type         nxt_in;
   logic [ACC_W-1:0] m;
   logic [ACC_W-1:0] tgt;
   logic [ACC_W-1:0] cand;

   // trial per lane
   always_comb begin
      nxt_in = cell_in;
      m      = '0;
      tgt    = '0;
      cand   = '0;
      for (int l = 0; l < LANES; l++) begin
         if (l == 0) begin
            m   = ACC_W'(1);
            tgt = ACC_W'(cell_in.lsq);
         end else begin
            m   = ACC_W'(cell_in.lsq);
            tgt = cell_in.num[l-1];
         end
         cand = cell_in.sq[l] + (cell_in.lin[l] << (BIT + 1)) + (m << (2 * BIT));
         if (cand <= tgt) begin
            nxt_in.sq[l]  = cand;
            nxt_in.lin[l] = cell_in.lin[l] + (m << BIT);
            nxt_in.q[l]   = cell_in.q[l] | (ROOT_W'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= nxt_in.valid;
      end
      if (en) begin
         cell_ff[$bits(cell_type)-2:0] <= nxt_in[$bits(cell_type)-2:0];
      end
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/vector3_math_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_math_unit: fixed-point dot, cross, length and normalize
// Q4.12 vectors in; products in Q.24, length and unit vector in Q.12.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  req     | req_valid/req_stall, opcode, a, b   | in
//  rsp     | rsp_valid/rsp_stall, status, r_x..z | out
//
//  One request per cycle while req_stall is low; registered stages are the input
//  register, products, sums, 17 root cells one bit each, and the output register.
//  The whole chain advances together; it holds while a result waits under
//  rsp_stall, and req_stall follows that condition.
//  Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_math_unit import v3mu_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_opcode,
   input  wire logic signed [COMP_W-1:0] req_a_x,
   input  wire logic signed [COMP_W-1:0] req_a_y,
   input  wire logic signed [COMP_W-1:0] req_a_z,
   input  wire logic signed [COMP_W-1:0] req_b_x,
   input  wire logic signed [COMP_W-1:0] req_b_y,
   input  wire logic signed [COMP_W-1:0] req_b_z,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_status,
   output logic signed [RES_W-1:0]       rsp_r_x,
   output logic signed [RES_W-1:0]       rsp_r_y,
   output logic signed [RES_W-1:0]       rsp_r_z
);

   logic                    en;
   cell_type                chain [ROOT_W+1];
   cell_type                tail;

   logic                    rsp_valid_ff;
   logic                    status_ff;
   logic signed [RES_W-1:0] rx_ff, ry_ff, rz_ff;
   logic                    status_in;
   logic signed [RES_W-1:0] rx_in, ry_in, rz_in;
   logic signed [RES_W-1:0] mag [3];

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   v3mu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_a_x    (req_a_x),
      .req_a_y    (req_a_y),
      .req_a_z    (req_a_z),
      .req_b_x    (req_b_x),
      .req_b_y    (req_b_y),
      .req_b_z    (req_b_z),
      .cell_out   (chain[0])
   );

   // cells from the top bit down
   for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
      v3mu_cell #(
         .BIT (ROOT_W - 1 - g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   assign tail = chain[ROOT_W];

   // result select
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = tail.neg[i] ? -RES_W'(tail.q[i+1]) : RES_W'(tail.q[i+1]);
      end
      status_in = 1'b0;
      rx_in     = tail.sc_x;
      ry_in     = tail.sc_y;
      rz_in     = tail.sc_z;
      case (tail.op)
         OP_LEN: begin
            rx_in = RES_W'(tail.q[0]);
         end
         OP_NORM: begin
            if (tail.lsq == '0) begin
               status_in = 1'b1;
               rx_in     = '0;
               ry_in     = '0;
               rz_in     = '0;
            end else begin
               rx_in = mag[0];
               ry_in = mag[1];
               rz_in = mag[2];
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tail.valid;
      end
      if (en) begin
         status_ff <= status_in;
         rx_ff     <= rx_in;
         ry_ff     <= ry_in;
         rz_ff     <= rz_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_r_x    = rx_ff;
   assign rsp_r_y    = ry_ff;
   assign rsp_r_z    = rz_ff;

endmodule

`default_nettype wire

// ===== rtl/v3mu_checker.sv =====
// ----------------------------------------------------------------------------
// v3mu_checker: port-level checks for the vector math unit
// Watches the request and response ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_checker import v3mu_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_status,
   input wire logic signed [RES_W-1:0]  rsp_r_x,
   input wire logic signed [RES_W-1:0]  rsp_r_y,
   input wire logic signed [RES_W-1:0]  rsp_r_z
);

   // no response in the first cycle after reset is released
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped under stall");

   // request side stalls only behind a blocked response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked response");

   // error status carries a zero vector
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0))
      else $error("error status with nonzero result");

endmodule

bind vector3_math_unit v3mu_checker u_v3mu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_r_x    (rsp_r_x),
   .rsp_r_y    (rsp_r_y),
   .rsp_r_z    (rsp_r_z)
);

`default_nettype wire
